[hw/rtl/hs_pkg.sv]
// heap sorter package: widths, controller states, command and status structs
// no dependencies; used by the interfaces and every module of the heap sorter

package hs_pkg;

   localparam int HS_MAX_ITEMS = 64;
   localparam int HS_DATA_W    = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PREP,
      ST_SIFT_RD,
      ST_SIFT_LDV,
      ST_EXT_RD0,
      ST_EXT_RDK,
      ST_EXT_WR,
      ST_RD_L,
      ST_RD_R,
      ST_CMP,
      ST_OUT_RD,
      ST_OUT_LD
   } hs_state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_ZERO,
      RD_K,
      RD_LC,
      RD_RC,
      RD_OUT
   } hs_rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_LOAD,
      WR_POS_V,
      WR_POS_CHILD,
      WR_K_TMP
   } hs_wr_sel_type;

   typedef struct packed {
      logic          load;
      logic          init;
      logic          pos_root;
      logic          cap_v;
      logic          cap_left;
      logic          cap_tmp;
      logic          ext_start;
      logic          init_ext;
      logic          dec_root;
      logic          dec_k;
      logic          pos_child;
      logic          out_load;
      logic          out_next;
      hs_rd_sel_type rd_sel;
      hs_wr_sel_type wr_sel;
   } hs_cmd_type;

   typedef struct packed {
      logic count_lt2;
      logic lc_ok;
      logic rc_ok;
      logic child_wins;
      logic root_zero;
      logic k_one;
      logic out_last;
      logic rsp_free;
   } hs_stat_type;

endpackage

[hw/rtl/hs_if.sv]
// valid/ready channel interfaces of the heap sorter: request and response
// depends on hs_pkg for the data width

interface hs_req_if import hs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [HS_DATA_W-1:0] value;
   logic                        is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface hs_rsp_if import hs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [HS_DATA_W-1:0] sorted_value;
   logic                        last_out;
   logic                        overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

[hw/rtl/hs_datapath.sv]
// heap sorter datapath: element memory, index registers, sift compare, output register
// depends on hs_pkg; driven by hs_ctrl through hs_cmd_type

module hs_datapath import hs_pkg::*; #(
   parameter int MAX_ITEMS = HS_MAX_ITEMS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hs_cmd_type                  cmd,
   output hs_stat_type                 stat,
   input  logic signed [HS_DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [HS_DATA_W-1:0] rsp_sorted_value,
   output logic                        rsp_last_out,
   output logic                        rsp_overflow
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [HS_DATA_W-1:0] mem [MAX_ITEMS];

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] root_ff, root_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] size_ff, size_in;
   logic [AW-1:0] out_idx_ff, out_idx_in;

   logic signed [HS_DATA_W-1:0] v_ff, left_ff, tmp_ff, rd_data_ff;
   logic signed [HS_DATA_W-1:0] rsp_value_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff, rsp_ovf_ff;

   logic [AW+1:0]               lc, rc;
   logic                        room, l_gt, r_gt;
   logic signed [HS_DATA_W-1:0] cand, child_val;
   logic [AW-1:0]               child_idx;
   logic                        rd_en, wr_en;
   logic [AW-1:0]               rd_addr, wr_addr;
   logic [HS_DATA_W-1:0]        wr_data;

   // heap children of the current position
   assign lc   = {1'b0, pos_ff, 1'b1};
   assign rc   = ({2'b00, pos_ff} + (AW+2)'(1)) << 1;
   assign room = count_ff < CW'(MAX_ITEMS);

   // larger child must beat the sifted value, right only if strictly above left
   assign l_gt      = stat.lc_ok && (left_ff > v_ff);
   assign cand      = l_gt ? left_ff : v_ff;
   assign r_gt      = stat.rc_ok && (rd_data_ff > cand);
   assign child_val = r_gt ? rd_data_ff : left_ff;
   assign child_idx = r_gt ? rc[AW-1:0] : lc[AW-1:0];

   always_comb begin
      stat.count_lt2  = count_ff < CW'(2);
      stat.lc_ok      = lc < (AW+2)'(size_ff);
      stat.rc_ok      = rc < (AW+2)'(size_ff);
      stat.child_wins = l_gt || r_gt;
      stat.root_zero  = root_ff == '0;
      stat.k_one      = k_ff == AW'(1);
      stat.out_last   = (CW'(out_idx_ff) + CW'(1)) == count_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_en = cmd.rd_sel != RD_NONE;
      case (cmd.rd_sel)
         RD_ROOT: rd_addr = root_ff;
         RD_K:    rd_addr = k_ff;
         RD_LC:   rd_addr = lc[AW-1:0];
         RD_RC:   rd_addr = rc[AW-1:0];
         RD_OUT:  rd_addr = out_idx_ff;
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = pos_ff;
      wr_data = v_ff;
      case (cmd.wr_sel)
         WR_LOAD: begin
            wr_en   = room;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_value;
         end
         WR_POS_V: begin
            wr_addr = pos_ff;
            wr_data = v_ff;
         end
         WR_POS_CHILD: begin
            wr_addr = pos_ff;
            wr_data = child_val;
         end
         WR_K_TMP: begin
            wr_addr = k_ff;
            wr_data = tmp_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      root_in      = root_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.init) begin
         root_in    = AW'((count_ff >> 1) - CW'(1));
         out_idx_in = '0;
      end
      if (cmd.pos_root) begin
         pos_in  = root_ff;
         size_in = count_ff;
      end
      if (cmd.dec_root) begin
         root_in = root_ff - AW'(1);
      end
      if (cmd.init_ext) begin
         k_in = AW'(count_ff - CW'(1));
      end
      if (cmd.dec_k) begin
         k_in = k_ff - AW'(1);
      end
      if (cmd.ext_start) begin
         pos_in  = '0;
         size_in = CW'(k_ff);
      end
      if (cmd.pos_child) begin
         pos_in = child_idx;
      end
      if (cmd.out_next) begin
         out_idx_in = out_idx_ff + AW'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         // batch ends with its last result
         if (stat.out_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff    <= root_in;
      k_ff       <= k_in;
      pos_ff     <= pos_in;
      size_ff    <= size_in;
      out_idx_ff <= out_idx_in;
      if (cmd.cap_v) begin
         v_ff <= rd_data_ff;
      end
      if (cmd.cap_left) begin
         left_ff <= rd_data_ff;
      end
      if (cmd.cap_tmp) begin
         tmp_ff <= rd_data_ff;
      end
      if (cmd.out_load) begin
         rsp_value_ff <= rd_data_ff;
         rsp_last_ff  <= stat.out_last;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("memory read and write at the same address");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && stat.out_last) |=> (count_ff == '0 && !ovf_ff))
      else $error("batch state not cleared after last result");

endmodule

[hw/rtl/hs_ctrl.sv]
// heap sorter controller: load, heap build, extraction and output sequencing
// depends on hs_pkg; drives hs_datapath through hs_cmd_type

module hs_ctrl import hs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_is_last,
   output logic        req_ready,
   input  hs_stat_type stat,
   output hs_cmd_type  cmd
);

   hs_state_type state_ff, state_in;
   logic         phase_ff, phase_in;   // 0 heap build, 1 extraction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_NONE;
      cmd.wr_sel = WR_NONE;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               cmd.wr_sel = WR_LOAD;
               if (req_is_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.init = 1'b1;
            phase_in = 1'b0;
            state_in = stat.count_lt2 ? ST_OUT_RD : ST_SIFT_RD;
         end
         ST_SIFT_RD: begin
            cmd.rd_sel   = RD_ROOT;
            cmd.pos_root = 1'b1;
            state_in     = ST_SIFT_LDV;
         end
         ST_SIFT_LDV: begin
            cmd.cap_v = 1'b1;
            state_in  = ST_RD_L;
         end
         ST_EXT_RD0: begin
            cmd.rd_sel = RD_ZERO;
            state_in   = ST_EXT_RDK;
         end
         ST_EXT_RDK: begin
            cmd.cap_tmp = 1'b1;
            cmd.rd_sel  = RD_K;
            state_in    = ST_EXT_WR;
         end
         ST_EXT_WR: begin
            // old root goes to the end, old end value sifts down from the root
            cmd.cap_v     = 1'b1;
            cmd.ext_start = 1'b1;
            cmd.wr_sel    = WR_K_TMP;
            state_in      = ST_RD_L;
         end
         ST_RD_L: begin
            if (stat.lc_ok) begin
               cmd.rd_sel = RD_LC;
               state_in   = ST_RD_R;
            end else begin
               cmd.wr_sel = WR_POS_V;
            end
         end
         ST_RD_R: begin
            cmd.cap_left = 1'b1;
            if (stat.rc_ok) begin
               cmd.rd_sel = RD_RC;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.child_wins) begin
               cmd.wr_sel    = WR_POS_CHILD;
               cmd.pos_child = 1'b1;
               state_in      = ST_RD_L;
            end else begin
               cmd.wr_sel = WR_POS_V;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_sel = RD_OUT;
            state_in   = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               if (stat.out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // end of one sift: pick the next root, the next extraction or the output
      if (cmd.wr_sel == WR_POS_V) begin
         if (!phase_ff) begin
            if (stat.root_zero) begin
               cmd.init_ext = 1'b1;
               phase_in     = 1'b1;
               state_in     = ST_EXT_RD0;
            end else begin
               cmd.dec_root = 1'b1;
               state_in     = ST_SIFT_RD;
            end
         end else if (stat.k_one) begin
            state_in = ST_OUT_RD;
         end else begin
            cmd.dec_k = 1'b1;
            state_in  = ST_EXT_RD0;
         end
      end
   end

   a_cmp_has_child: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> stat.lc_ok)
      else $error("compare step without a left child");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.rsp_free)
      else $error("output register overwritten while full");

   a_sort_needs_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP && stat.count_lt2) |=> (state_ff == ST_OUT_RD))
      else $error("sort started on fewer than two items");

endmodule

[hw/rtl/heap_sorter_unit.sv]
// Heap sorter: items arrive on req_bus one per cycle while loading and are stored
// until the item marked is_last; the stored batch (up to MAX_ITEMS values, extra
// items dropped and flagged as overflow on every result of that batch) is then
// heap-sorted in place in a single-port-read element memory and sent out on
// rsp_bus in ascending order, last_out marking the largest. Each heap level of
// every sift-down reads the left and right child through the one memory read port
// and writes one entry. Each result is read from memory and then loaded into the
// output register, which takes a new result only when rsp_bus has taken or is
// taking the previous one. The next batch is accepted as soon as the last result
// sits in the output register. Depends on hs_pkg, hs_if, hs_datapath and hs_ctrl.

module heap_sorter_unit import hs_pkg::*; #(
   parameter int MAX_ITEMS = HS_MAX_ITEMS   // batch capacity, 2 to 64
) (
   input  logic      clock,
   input  logic      reset,
   hs_req_if.sink    req_bus,
   hs_rsp_if.source  rsp_bus
);

   // command and status between sequencer and datapath
   hs_cmd_type  cmd;
   hs_stat_type stat;

   // sequencer: owns the request handshake and the sort phases
   hs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_is_last (req_bus.is_last),
      .req_ready   (req_bus.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // datapath: element memory, heap indices and the registered result item
   hs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_bus.value),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_sorted_value (rsp_bus.sorted_value),
      .rsp_last_out     (rsp_bus.last_out),
      .rsp_overflow     (rsp_bus.overflow)
   );

endmodule
